>>> src/oks_pkg.sv
// shared types and constants of the ordered key set
package oks_pkg;
   localparam int CAPACITY = 256;
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int KEY_W = 32;

   typedef enum logic [2:0] {
      KIND_INSERT = 3'd0,
      KIND_DELETE = 3'd1,
      KIND_EXISTS = 3'd2,
      KIND_SUCC   = 3'd3,
      KIND_PRED   = 3'd4
   } kind_type;
endpackage

>>> src/ordered_key_set_top.sv
// top level of the ordered key set: sorted key memory with search and shift sequencer
//
// Usage:
//   req channel carries one operation per item: tuser = kind (insert, delete,
//   exists, successor, predecessor), tdata = 32-bit signed key.
//   rsp channel returns one item per request: tdata = found, value, status.
//   Keys sit in ascending order (sign bit flipped) in one memory with a
//   registered read. A binary search takes p probes (address, then registered
//   data), p at most ADDR_W+1. Exists, repeated or refused insert, delete of an
//   absent key and unused kinds answer once the search ends; predecessor then
//   reads the neighbor entry. Successor runs a second search of q probes and
//   reads the entry it finds. Insert and delete then move the tail entry by entry.
//   One item is in flight at a time; the next request is taken the cycle after
//   its result is accepted.
//   Reset empties the set (key_count to zero); memory contents need no clearing.
//   A finished result waits in the output register while rsp_tready is low.
module ordered_key_set_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // key
   input  logic [2:0]  req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // found, value[32:1], status, zero fill
);
   import oks_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SRCH_RD, ST_SRCH_CMP, ST_PRED_RD, ST_SHIFT_RD, ST_SHIFT_WR, ST_DONE
   } state_type;

   logic [KEY_W-1:0] mem [CAPACITY];
   logic [KEY_W-1:0] rdata_ff;
   logic [ADDR_W-1:0] raddr;
   logic             we;
   logic [ADDR_W-1:0] waddr;
   logic [KEY_W-1:0] wdata;

   state_type        state_ff;
   logic [2:0]       kind_ff;
   logic [KEY_W-1:0] bkey_ff;
   logic [CNT_W-1:0] count_ff, lo_ff, hi_ff, lo2_ff, hi2_ff, idx_ff;
   logic             phase_ff;      // 0 lower bound search, 1 upper bound search
   logic             present_ff;
   logic [KEY_W-1:0] carry_ff;
   logic             out_valid_ff;
   logic             found_ff, status_ff;
   logic [KEY_W-1:0] value_ff;
   logic [CNT_W-1:0] mid;

   // memory with registered read
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   // read address and write port selection
   always_comb begin
      raddr = mid[ADDR_W-1:0];
      we = 1'b0;
      waddr = idx_ff[ADDR_W-1:0];
      wdata = carry_ff;
      case (state_ff)
         ST_PRED_RD:  raddr = idx_ff[ADDR_W-1:0];
         ST_SHIFT_RD: raddr = idx_ff[ADDR_W-1:0];
         ST_SHIFT_WR: we = 1'b1;
         default: ;
      endcase
      // delete moves each entry one place down
      if (state_ff == ST_SHIFT_WR && kind_ff == KIND_DELETE) begin
         wdata = rdata_ff;
         waddr = ADDR_W'(idx_ff - 1'b1);
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {6'd0, status_ff, value_ff, found_ff};

   // sequencer: search, optional neighbor read, shift, result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               kind_ff <= req_tuser;
               bkey_ff <= {~req_tdata[31], req_tdata[30:0]};
               value_ff <= req_tdata;
               lo_ff <= '0;
               hi_ff <= count_ff;
               phase_ff <= 1'b0;
               present_ff <= 1'b0;
               found_ff <= 1'b0;
               status_ff <= 1'b0;
               state_ff <= ST_SRCH_RD;
            end
            ST_SRCH_RD: begin
               if (lo_ff < hi_ff) state_ff <= ST_SRCH_CMP;
               else if (!phase_ff) begin
                  // lower bound done, lo_ff = pos
                  lo2_ff <= lo_ff;
                  case (kind_ff)
                     KIND_SUCC: begin
                        phase_ff <= 1'b1;
                        hi_ff <= count_ff;
                     end
                     KIND_PRED: begin
                        state_ff <= ST_PRED_RD;
                        idx_ff <= CNT_W'(lo_ff - 1'b1);
                     end
                     KIND_INSERT: begin
                        if (present_ff) begin
                           found_ff <= 1'b1;
                           state_ff <= ST_DONE;
                        end else if (count_ff == CNT_W'(CAPACITY)) begin
                           status_ff <= 1'b1;
                           state_ff <= ST_DONE;
                        end else begin
                           carry_ff <= bkey_ff;
                           idx_ff <= lo_ff;
                           state_ff <= ST_SHIFT_RD;
                        end
                     end
                     KIND_DELETE: begin
                        found_ff <= present_ff;
                        if (present_ff) begin
                           idx_ff <= lo_ff + 1'b1;
                           state_ff <= ST_SHIFT_RD;
                        end else state_ff <= ST_DONE;
                     end
                     KIND_EXISTS: begin
                        found_ff <= present_ff;
                        state_ff <= ST_DONE;
                     end
                     default: begin
                        value_ff <= '0;
                        state_ff <= ST_DONE;
                     end
                  endcase
               end else begin
                  hi2_ff <= lo_ff;
                  idx_ff <= lo_ff;
                  state_ff <= ST_PRED_RD;
               end
            end
            ST_SRCH_CMP: begin
               if (rdata_ff < bkey_ff || (phase_ff && rdata_ff == bkey_ff))
                  lo_ff <= mid + 1'b1;
               else hi_ff <= mid;
               // an equal key is always probed by the lower bound search
               if (!phase_ff && rdata_ff == bkey_ff) present_ff <= 1'b1;
               state_ff <= ST_SRCH_RD;
            end
            ST_PRED_RD: begin
               // issue read at idx; the data is valid in the ST_SHIFT_RD state that follows
               state_ff <= ST_SHIFT_RD;
            end
            ST_SHIFT_RD: begin
               case (kind_ff)
                  KIND_SUCC: begin
                     if (hi2_ff < count_ff) begin
                        found_ff <= 1'b1;
                        value_ff <= {~rdata_ff[31], rdata_ff[30:0]};
                     end else value_ff <= '0;
                     state_ff <= ST_DONE;
                  end
                  KIND_PRED: begin
                     if (lo2_ff != 0) begin
                        found_ff <= 1'b1;
                        value_ff <= {~rdata_ff[31], rdata_ff[30:0]};
                     end else value_ff <= '0;
                     state_ff <= ST_DONE;
                  end
                  KIND_DELETE: begin
                     if (idx_ff < count_ff) state_ff <= ST_SHIFT_WR;
                     else begin
                        count_ff <= count_ff - 1'b1;
                        state_ff <= ST_DONE;
                     end
                  end
                  default: begin
                     // insert: old entry at idx arrives next cycle
                     state_ff <= ST_SHIFT_WR;
                  end
               endcase
            end
            ST_SHIFT_WR: begin
               if (kind_ff == KIND_INSERT) begin
                  // write the carried key, carry the displaced one upward
                  carry_ff <= rdata_ff;
                  if (idx_ff == count_ff) begin
                     count_ff <= count_ff + 1'b1;
                     state_ff <= ST_DONE;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_SHIFT_RD;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= ST_SHIFT_RD;
               end
            end
            ST_DONE: begin
               // output register is always free here
               out_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result item holds steady while the receiver stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata));

   // no request is taken while a result waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid));

   // key count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY));
endmodule
